// ===== rtl/core/fsmf_pkg.sv =====
// Package for the four-template F-statistic matched filter.
// Holds format constants and the saturating fixed-point helper functions.
// No dependencies.
package fsmf_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int ACC_BITS    = 64;
	localparam int NOISE_BITS  = 32;
	localparam int NOISE_FRAC  = 16;
	localparam int FRAC_BITS   = 2 * (SAMPLE_BITS - 1);
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;
	localparam int WIDE_BITS   = 2 * ACC_BITS;
	localparam int CNT_BITS    = $clog2(WIDE_BITS + 1);

	localparam logic [ACC_BITS-1:0] SAT_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic [ACC_BITS-1:0] SAT_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
	localparam logic [ACC_BITS-1:0] FIX_ONE = {{(ACC_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;
	// largest quotient that may still be scaled by 4 without overflow
	localparam logic [ACC_BITS-1:0] TERM_LIMIT = SAT_MAX >> 2;

	function automatic logic [ACC_BITS-1:0] mag64(input logic [ACC_BITS-1:0] v);
		return v[ACC_BITS-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [ACC_BITS-1:0] sext_smp(input logic [SAMPLE_BITS-1:0] x);
		return {{(ACC_BITS-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
	endfunction

	function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
			input logic [ACC_BITS-1:0] b);
		logic [ACC_BITS:0] s;
		s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
		if (s[ACC_BITS] != s[ACC_BITS-1]) begin
			return s[ACC_BITS] ? SAT_MIN : SAT_MAX;
		end
		return s[ACC_BITS-1:0];
	endfunction

	function automatic logic [ACC_BITS-1:0] sat_sub(input logic [ACC_BITS-1:0] a,
			input logic [ACC_BITS-1:0] b);
		logic [ACC_BITS:0] s;
		s = {a[ACC_BITS-1], a} - {b[ACC_BITS-1], b};
		if (s[ACC_BITS] != s[ACC_BITS-1]) begin
			return s[ACC_BITS] ? SAT_MIN : SAT_MAX;
		end
		return s[ACC_BITS-1:0];
	endfunction

	// fixed-point product: drop FRAC_BITS, saturate magnitude, apply sign
	function automatic logic [ACC_BITS-1:0] prod_sat(input logic [WIDE_BITS-1:0] p,
			input logic neg);
		logic [ACC_BITS-2:0] m;
		m = (|p[WIDE_BITS-1:FRAC_BITS+ACC_BITS-1]) ? SAT_MAX[ACC_BITS-2:0]
			: p[FRAC_BITS+ACC_BITS-2:FRAC_BITS];
		return neg ? (~{1'b0, m} + 1'b1) : {1'b0, m};
	endfunction

	function automatic logic [ACC_BITS-1:0] quo_sat(input logic [WIDE_BITS-1:0] q,
			input logic neg);
		logic [ACC_BITS-2:0] m;
		m = (|q[WIDE_BITS-1:ACC_BITS-1]) ? SAT_MAX[ACC_BITS-2:0] : q[ACC_BITS-2:0];
		return neg ? (~{1'b0, m} + 1'b1) : {1'b0, m};
	endfunction

	// upper-triangle slot of matrix entry (r, c)
	function automatic logic [3:0] tri_idx(input logic [1:0] r, input logic [1:0] c);
		logic [3:0] t;
		unique case ({r, c})
			4'b0000: t = 4'd0;
			4'b0001, 4'b0100: t = 4'd1;
			4'b0010, 4'b1000: t = 4'd2;
			4'b0011, 4'b1100: t = 4'd3;
			4'b0101: t = 4'd4;
			4'b0110, 4'b1001: t = 4'd5;
			4'b0111, 4'b1101: t = 4'd6;
			4'b1010: t = 4'd7;
			4'b1011, 4'b1110: t = 4'd8;
			default: t = 4'd9;
		endcase
		return t;
	endfunction

	// row and column of upper-triangle slot g, packed {row, col}
	function automatic logic [3:0] gram_rc(input logic [3:0] g);
		logic [3:0] rc;
		unique case (g)
			4'd0: rc = 4'b0000;
			4'd1: rc = 4'b0001;
			4'd2: rc = 4'b0010;
			4'd3: rc = 4'b0011;
			4'd4: rc = 4'b0101;
			4'd5: rc = 4'b0110;
			4'd6: rc = 4'b0111;
			4'd7: rc = 4'b1010;
			4'd8: rc = 4'b1011;
			default: rc = 4'b1111;
		endcase
		return rc;
	endfunction

endpackage

// ===== rtl/core/fsmf_mul.sv =====
// Shared unsigned 64x64 multiplier built from one 32x32 multiplier.
// Four partial products, accumulated into a 128-bit result.
// Depends on fsmf_pkg.
module fsmf_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [fsmf_pkg::ACC_BITS-1:0]       a,
	input  logic [fsmf_pkg::ACC_BITS-1:0]       b,
	output logic                                done,
	output logic [fsmf_pkg::WIDE_BITS-1:0]      prod
);
	localparam int HB = fsmf_pkg::ACC_BITS / 2;

	logic [fsmf_pkg::ACC_BITS-1:0]  a_q, b_q;
	logic [2:0]                     cnt_q;
	logic                           run_q, done_q;
	logic [fsmf_pkg::ACC_BITS-1:0]  pp_s1;
	logic [1:0]                     sh_s1;
	logic [fsmf_pkg::WIDE_BITS-1:0] acc_q;
	logic [HB-1:0]                  opa, opb;
	logic [1:0]                     sh;
	logic [fsmf_pkg::WIDE_BITS-1:0] pp_ext;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin opa = a_q[HB-1:0]; opb = b_q[HB-1:0]; sh = 2'd0; end
			2'd1: begin opa = a_q[HB-1:0]; opb = b_q[2*HB-1:HB]; sh = 2'd1; end
			2'd2: begin opa = a_q[2*HB-1:HB]; opb = b_q[HB-1:0]; sh = 2'd1; end
			default: begin opa = a_q[2*HB-1:HB]; opb = b_q[2*HB-1:HB]; sh = 2'd2; end
		endcase
	end

	always_comb begin
		unique case (sh_s1)
			2'd0: pp_ext = {{(2*HB){1'b0}}, pp_s1};
			2'd1: pp_ext = {{HB{1'b0}}, pp_s1, {HB{1'b0}}};
			default: pp_ext = {pp_s1, {(2*HB){1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q   <= a;
				b_q   <= b;
				cnt_q <= '0;
				run_q <= 1'b1;
				acc_q <= '0;
			end else if (run_q) begin
				if (!cnt_q[2]) begin
					pp_s1 <= opa * opb;
					sh_s1 <= sh;
				end
				if (cnt_q != 3'd0) begin
					acc_q <= acc_q + pp_ext;
				end
				if (cnt_q[2]) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

// ===== rtl/core/fsmf_div.sv =====
// Shared bit-serial unsigned divider, one quotient bit per cycle.
// Long mode: 128-bit dividend; short mode: low 64 bits only, 64 steps.
// Depends on fsmf_pkg.
module fsmf_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                short_mode,
	input  logic [fsmf_pkg::WIDE_BITS-1:0]      dividend,
	input  logic [fsmf_pkg::ACC_BITS-1:0]       divisor,
	output logic                                done,
	output logic [fsmf_pkg::WIDE_BITS-1:0]      quo
);
	localparam int AB = fsmf_pkg::ACC_BITS;
	localparam int WB = fsmf_pkg::WIDE_BITS;

	logic [WB-1:0]                 dvd_q, quo_q;
	logic [AB-1:0]                 dsr_q, rem_q;
	logic [fsmf_pkg::CNT_BITS-1:0] cnt_q;
	logic                          run_q, done_q;
	logic [AB:0]                   trial, diff;
	logic                          ge;

	assign trial = {rem_q, dvd_q[WB-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q <= short_mode ? {dividend[AB-1:0], {AB{1'b0}}} : dividend;
				dsr_q <= divisor;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= short_mode ? fsmf_pkg::CNT_BITS'(AB) : fsmf_pkg::CNT_BITS'(WB);
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= ge ? diff[AB-1:0] : trial[AB-1:0];
				dvd_q <= {dvd_q[WB-2:0], 1'b0};
				quo_q <= {quo_q[WB-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == fsmf_pkg::CNT_BITS'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ===== rtl/core/fstat_matched_filter.sv =====
// Four-template F-statistic matched filter: sequencer, sums and inversion work matrix.
// Each bin item runs 14 product terms (a zero-noise bin runs none); the work per term is set
// mostly by the bit-serial divider, 64 steps per term.
// The last bin then inverts the work matrix, mostly sixteen 128-step pivot divisions
// (fewer when a zero pivot ends the inversion early).
// One item at a time; the result waits in output registers while the next item enters.
// Reset clears the sums and the sequencer; the work matrix is filled before use.
module fstat_matched_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] data_re,
	input  logic signed [23:0] data_im,
	input  logic signed [23:0] tmpl1_re,
	input  logic signed [23:0] tmpl1_im,
	input  logic signed [23:0] tmpl2_re,
	input  logic signed [23:0] tmpl2_im,
	input  logic signed [23:0] tmpl3_re,
	input  logic signed [23:0] tmpl3_im,
	input  logic signed [23:0] tmpl4_re,
	input  logic signed [23:0] tmpl4_im,
	input  logic        [31:0] noise_psd,
	input  logic               last_bin,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] fstat,
	output logic signed [63:0] amp1,
	output logic signed [63:0] amp2,
	output logic signed [63:0] amp3,
	output logic signed [63:0] amp4,
	output logic               singular
);
	localparam int SB = fsmf_pkg::SAMPLE_BITS;
	localparam int AB = fsmf_pkg::ACC_BITS;
	localparam int WB = fsmf_pkg::WIDE_BITS;
	localparam int PB = fsmf_pkg::PROD_BITS;

	typedef enum logic [23:0] {
		S_IDLE = 24'h000001, S_BX  = 24'h000002, S_BM1 = 24'h000004, S_BW1 = 24'h000008,
		S_BM2  = 24'h000010, S_BW2 = 24'h000020, S_BDS = 24'h000040, S_BDV = 24'h000080,
		S_BAC  = 24'h000100, S_CPY = 24'h000200, S_PIV = 24'h000400, S_NRD = 24'h000800,
		S_NDV  = 24'h001000, S_ERW = 24'h002000, S_EM  = 24'h004000, S_EW  = 24'h008000,
		S_ES   = 24'h010000, S_AM  = 24'h020000, S_AW  = 24'h040000, S_AA  = 24'h080000,
		S_FM   = 24'h100000, S_FW  = 24'h200000, S_FA  = 24'h400000, S_OUT = 24'h800000
	} state_t;

	state_t state_q;

	logic [SB-1:0]   dre_q, dim_q, x1_q, x2_q, y2_q;
	logic [SB-1:0]   tre_q [4];
	logic [SB-1:0]   tim_q [4];
	logic [31:0]     noise_q;
	logic            last_q;
	logic [AB-1:0]   corr_q [4];
	logic [AB-1:0]   gram_q [10];
	logic [AB-1:0]   w_q [16];
	logic [AB-1:0]   amp_q [4];
	logic [AB-1:0]   fs_q, p_q, f_q, q_q, bterm_q;
	logic [PB-1:0]   p1_q;
	logic [PB:0]     sum_q;
	logic            mneg_q, nneg_q, sing_q;
	logic [3:0]      cnt_q;
	logic [1:0]      i_q, j_q, k_q;

	logic [AB-1:0]   fstat_q, amp1_q, amp2_q, amp3_q, amp4_q;
	logic            out_valid_q, singular_q;

	// read ports
	logic [3:0]      g_idx, rc, gram_ridx, w_ridx;
	logic [1:0]      t_idx, row, col, corr_ridx;
	logic            is_corr;
	logic [SB-1:0]   tre_rd, tim_rd;
	logic [AB-1:0]   w_rd, corr_rd, gram_rd, amp_rd;

	// shared units
	logic            mul_start, mul_done, mul_neg;
	logic [AB-1:0]   mul_a, mul_b;
	logic [WB-1:0]   mul_prod;
	logic            div_start, div_short, div_done;
	logic [WB-1:0]   div_dvd, div_quo;
	logic [AB-1:0]   div_dsr;

	logic [PB-1:0]   p_signed;
	logic [PB:0]     sum_abs;
	logic [AB-1:0]   bq, bterm;
	logic [AB-2:0]   bmag;
	logic [AB-1:0]   fs_half;
	logic            out_free;

	assign g_idx   = cnt_q - 4'd4;
	assign rc      = fsmf_pkg::gram_rc(g_idx);
	assign is_corr = cnt_q < 4'd4;
	assign row     = rc[3:2];
	assign col     = is_corr ? cnt_q[1:0] : rc[1:0];
	assign t_idx   = (state_q == S_BX) ? row : col;
	assign tre_rd  = tre_q[t_idx];
	assign tim_rd  = tim_q[t_idx];

	always_comb begin
		unique case (state_q)
			S_PIV:        w_ridx = {k_q, k_q};
			S_NRD, S_EM:  w_ridx = {k_q, j_q};
			S_ERW:        w_ridx = {i_q, k_q};
			default:      w_ridx = {i_q, j_q};
		endcase
		unique case (state_q)
			S_AM:    corr_ridx = j_q;
			S_FM:    corr_ridx = i_q;
			default: corr_ridx = cnt_q[1:0];
		endcase
		gram_ridx = (state_q == S_CPY) ? fsmf_pkg::tri_idx(cnt_q[3:2], cnt_q[1:0]) : g_idx;
	end

	assign w_rd    = w_q[w_ridx];
	assign corr_rd = corr_q[corr_ridx];
	assign gram_rd = gram_q[gram_ridx];
	assign amp_rd  = amp_q[i_q];

	always_comb begin
		mul_start = 1'b1;
		unique case (state_q)
			S_BM1: begin
				mul_a   = fsmf_pkg::mag64(fsmf_pkg::sext_smp(x1_q));
				mul_b   = fsmf_pkg::mag64(fsmf_pkg::sext_smp(tre_rd));
				mul_neg = x1_q[SB-1] ^ tre_rd[SB-1];
			end
			S_BM2: begin
				mul_a   = fsmf_pkg::mag64(fsmf_pkg::sext_smp(x2_q));
				mul_b   = fsmf_pkg::mag64(fsmf_pkg::sext_smp(y2_q));
				mul_neg = x2_q[SB-1] ^ y2_q[SB-1];
			end
			S_EM: begin
				mul_a   = fsmf_pkg::mag64(w_rd);
				mul_b   = fsmf_pkg::mag64(f_q);
				mul_neg = w_rd[AB-1] ^ f_q[AB-1];
			end
			S_AM: begin
				mul_a   = fsmf_pkg::mag64(w_rd);
				mul_b   = fsmf_pkg::mag64(corr_rd);
				mul_neg = w_rd[AB-1] ^ corr_rd[AB-1];
			end
			S_FM: begin
				mul_a   = fsmf_pkg::mag64(corr_rd);
				mul_b   = fsmf_pkg::mag64(amp_rd);
				mul_neg = corr_rd[AB-1] ^ amp_rd[AB-1];
			end
			default: begin
				mul_start = 1'b0;
				mul_a     = '0;
				mul_b     = '0;
				mul_neg   = 1'b0;
			end
		endcase
	end

	assign sum_abs   = sum_q[PB] ? (~sum_q + 1'b1) : sum_q;
	assign div_start = (state_q == S_BDS) || (state_q == S_NRD);
	assign div_short = (state_q == S_BDS);
	assign div_dvd   = div_short
		? {{AB{1'b0}}, sum_abs[AB-fsmf_pkg::NOISE_FRAC-1:0], {fsmf_pkg::NOISE_FRAC{1'b0}}}
		: ({{AB{1'b0}}, fsmf_pkg::mag64(w_rd)} << fsmf_pkg::FRAC_BITS);
	assign div_dsr   = div_short ? {{(AB-fsmf_pkg::NOISE_BITS){1'b0}}, noise_q}
		: fsmf_pkg::mag64(p_q);

	fsmf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	fsmf_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.short_mode (div_short),
		.dividend   (div_dvd),
		.divisor    (div_dsr),
		.done       (div_done),
		.quo        (div_quo)
	);

	assign p_signed = mneg_q ? (~mul_prod[PB-1:0] + 1'b1) : mul_prod[PB-1:0];
	assign bq       = div_quo[AB-1:0];
	assign bmag     = (bq > fsmf_pkg::TERM_LIMIT) ? fsmf_pkg::SAT_MAX[AB-2:0]
		: {bq[AB-4:0], 2'b00};
	assign bterm    = nneg_q ? (~{1'b0, bmag} + 1'b1) : {1'b0, bmag};
	assign fs_half  = $signed(fs_q + {{(AB-1){1'b0}}, fs_q[AB-1]}) >>> 1;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			sing_q      <= 1'b0;
			cnt_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			for (int n = 0; n < 4; n++) corr_q[n] <= '0;
			for (int n = 0; n < 10; n++) gram_q[n] <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) out_valid_q <= 1'b0;
			if (mul_start) mneg_q <= mul_neg;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						dre_q    <= data_re;
						dim_q    <= data_im;
						tre_q[0] <= tmpl1_re;
						tim_q[0] <= tmpl1_im;
						tre_q[1] <= tmpl2_re;
						tim_q[1] <= tmpl2_im;
						tre_q[2] <= tmpl3_re;
						tim_q[2] <= tmpl3_im;
						tre_q[3] <= tmpl4_re;
						tim_q[3] <= tmpl4_im;
						noise_q  <= noise_psd;
						last_q   <= last_bin;
						cnt_q    <= '0;
						if (noise_psd != '0) state_q <= S_BX;
						else if (last_bin) state_q <= S_CPY;
					end
				end
				S_BX: begin
					x1_q    <= is_corr ? dre_q : tre_rd;
					x2_q    <= is_corr ? dim_q : tim_rd;
					state_q <= S_BM1;
				end
				S_BM1: begin
					y2_q    <= tim_rd;
					state_q <= S_BW1;
				end
				S_BW1: begin
					if (mul_done) begin
						p1_q    <= p_signed;
						state_q <= S_BM2;
					end
				end
				S_BM2: state_q <= S_BW2;
				S_BW2: begin
					if (mul_done) begin
						sum_q   <= {p1_q[PB-1], p1_q} + {p_signed[PB-1], p_signed};
						state_q <= S_BDS;
					end
				end
				S_BDS: begin
					nneg_q  <= sum_q[PB];
					state_q <= S_BDV;
				end
				S_BDV: begin
					if (div_done) begin
						bterm_q <= bterm;
						state_q <= S_BAC;
					end
				end
				S_BAC: begin
					if (is_corr) corr_q[corr_ridx] <= fsmf_pkg::sat_add(corr_rd, bterm_q);
					else gram_q[gram_ridx] <= fsmf_pkg::sat_add(gram_rd, bterm_q);
					if (cnt_q == 4'd13) begin
						cnt_q   <= '0;
						state_q <= last_q ? S_CPY : S_IDLE;
					end else begin
						cnt_q   <= cnt_q + 4'd1;
						state_q <= S_BX;
					end
				end
				S_CPY: begin
					w_q[cnt_q] <= gram_rd;
					cnt_q      <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						k_q     <= '0;
						state_q <= S_PIV;
					end
				end
				S_PIV: begin
					if (w_rd == '0) begin
						sing_q <= 1'b1;
						fs_q   <= '0;
						for (int n = 0; n < 4; n++) amp_q[n] <= '0;
						state_q <= S_OUT;
					end else begin
						p_q           <= w_rd;
						w_q[w_ridx]   <= fsmf_pkg::FIX_ONE;
						j_q           <= '0;
						state_q       <= S_NRD;
					end
				end
				S_NRD: begin
					nneg_q  <= w_rd[AB-1] ^ p_q[AB-1];
					state_q <= S_NDV;
				end
				S_NDV: begin
					if (div_done) begin
						w_q[{k_q, j_q}] <= fsmf_pkg::quo_sat(div_quo, nneg_q);
						if (j_q == 2'd3) begin
							i_q     <= '0;
							state_q <= S_ERW;
						end else begin
							j_q     <= j_q + 2'd1;
							state_q <= S_NRD;
						end
					end
				end
				S_ERW: begin
					if (i_q == k_q) begin
						if (i_q == 2'd3) begin
							i_q <= '0;
							j_q <= '0;
							if (k_q == 2'd3) state_q <= S_AM;
							else begin
								k_q     <= k_q + 2'd1;
								state_q <= S_PIV;
							end
						end else begin
							i_q <= i_q + 2'd1;
						end
					end else begin
						f_q         <= w_rd;
						w_q[w_ridx] <= '0;
						j_q         <= '0;
						state_q     <= S_EM;
					end
				end
				S_EM: state_q <= S_EW;
				S_EW: begin
					if (mul_done) begin
						q_q     <= fsmf_pkg::prod_sat(mul_prod, mneg_q);
						state_q <= S_ES;
					end
				end
				S_ES: begin
					w_q[w_ridx] <= fsmf_pkg::sat_sub(w_rd, q_q);
					if (j_q == 2'd3) begin
						j_q <= '0;
						if (i_q == 2'd3) begin
							i_q <= '0;
							if (k_q == 2'd3) state_q <= S_AM;
							else begin
								k_q     <= k_q + 2'd1;
								state_q <= S_PIV;
							end
						end else begin
							i_q     <= i_q + 2'd1;
							state_q <= S_ERW;
						end
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= S_EM;
					end
				end
				S_AM: state_q <= S_AW;
				S_AW: begin
					if (mul_done) begin
						q_q     <= fsmf_pkg::prod_sat(mul_prod, mneg_q);
						state_q <= S_AA;
					end
				end
				S_AA: begin
					amp_q[i_q] <= fsmf_pkg::sat_add((j_q == 2'd0) ? '0 : amp_rd, q_q);
					j_q        <= j_q + 2'd1;
					i_q        <= (j_q == 2'd3) ? i_q + 2'd1 : i_q;
					state_q    <= (j_q == 2'd3 && i_q == 2'd3) ? S_FM : S_AM;
				end
				S_FM: state_q <= S_FW;
				S_FW: begin
					if (mul_done) begin
						q_q     <= fsmf_pkg::prod_sat(mul_prod, mneg_q);
						state_q <= S_FA;
					end
				end
				S_FA: begin
					fs_q    <= fsmf_pkg::sat_add((i_q == 2'd0) ? '0 : fs_q, q_q);
					i_q     <= i_q + 2'd1;
					state_q <= (i_q == 2'd3) ? S_OUT : S_FM;
				end
				S_OUT: begin
					if (out_free) begin
						fstat_q     <= fs_half;
						amp1_q      <= amp_q[0];
						amp2_q      <= amp_q[1];
						amp3_q      <= amp_q[2];
						amp4_q      <= amp_q[3];
						singular_q  <= sing_q;
						out_valid_q <= 1'b1;
						sing_q      <= 1'b0;
						for (int n = 0; n < 4; n++) corr_q[n] <= '0;
						for (int n = 0; n < 10; n++) gram_q[n] <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign fstat     = fstat_q;
	assign amp1      = amp1_q;
	assign amp2      = amp2_q;
	assign amp3      = amp3_q;
	assign amp4      = amp4_q;
	assign singular  = singular_q;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("sequencer state not one-hot");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && singular_q) |-> (fstat_q == '0 && amp1_q == '0 && amp2_q == '0
			&& amp3_q == '0 && amp4_q == '0))
		else $error("singular result carries nonzero values");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (corr_q[0] == '0 && gram_q[9] == '0))
		else $error("sums not cleared after result");
endmodule

// ===== sim/fstat_matched_filter_tb.sv =====
// Testbench for fstat_matched_filter: drives bin items and checks each window result
// against an in-bench fixed-point predictor of the sums, Gram inversion and F-statistic.
// Depends on fsmf_pkg and rtl/core/fstat_matched_filter.sv.
module fstat_matched_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [23:0] d_re;
		logic signed [23:0] d_im;
		logic [3:0][23:0]   t_re;
		logic [3:0][23:0]   t_im;
		logic [31:0]        noise;
		logic               last;
	} bin_t;

	typedef struct {
		logic signed [63:0] fs;
		logic signed [63:0] amp [4];
		logic               sing;
	} fstat_res_t;

	localparam logic signed [63:0] I64_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;
	localparam int SMP_MAX = 8388607;
	localparam int SMP_MIN = -8388608;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [23:0] data_re = '0, data_im = '0;
	logic signed [23:0] tmpl1_re = '0, tmpl1_im = '0, tmpl2_re = '0, tmpl2_im = '0;
	logic signed [23:0] tmpl3_re = '0, tmpl3_im = '0, tmpl4_re = '0, tmpl4_im = '0;
	logic [31:0] noise_psd = '0;
	logic last_bin = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [63:0] fstat, amp1, amp2, amp3, amp4;
	logic singular;

	fstat_res_t window_results [$];
	logic signed [63:0] corr_acc [4];
	logic signed [63:0] gram_acc [10];
	int gram_slot [16] = '{0, 1, 2, 3, 1, 4, 5, 6, 2, 5, 7, 8, 3, 6, 8, 9};
	int errors = 0;
	int burst_left = 0;
	int hold_cycles = 0;
	int bins_sent = 0;

	fstat_matched_filter dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [127:0] mag128(input logic signed [63:0] v);
		logic signed [127:0] w;
		w = v;
		return w < 0 ? -w : w;
	endfunction

	function automatic logic signed [63:0] clamp_mag(input logic [127:0] m, input bit neg);
		logic [63:0] r;
		r = (m > 128'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : m[63:0];
		return neg ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return clamp_mag((mag128(a) * mag128(b)) >> fsmf_pkg::FRAC_BITS,
			(a < 0) != (b < 0));
	endfunction

	function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
			input logic signed [63:0] b);
		if (b == 0) return 0;
		return clamp_mag((mag128(a) << fsmf_pkg::FRAC_BITS) / mag128(b),
			(a < 0) != (b < 0));
	endfunction

	function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(I64_MAX)) return I64_MAX;
		if (s < 65'(I64_MIN)) return I64_MIN;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sub_clip(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'(I64_MAX)) return I64_MAX;
		if (s < 65'(I64_MIN)) return I64_MIN;
		return s[63:0];
	endfunction

	// 4*(p1+p2)/noise with noise in Q16.16
	function automatic logic signed [63:0] weighted_term(input logic signed [63:0] p1,
			input logic signed [63:0] p2, input logic [31:0] noise);
		logic signed [63:0] s;
		logic [127:0] q;
		s = p1 + p2;
		q = (mag128(s) << 16) / noise;
		if (q > 128'h1fff_ffff_ffff_ffff) q = 128'h7fff_ffff_ffff_ffff;
		else q = q << 2;
		return clamp_mag(q, s < 0);
	endfunction

	function automatic void clear_sums();
		foreach (corr_acc[i]) corr_acc[i] = 0;
		foreach (gram_acc[i]) gram_acc[i] = 0;
	endfunction

	function automatic void fold_bin(input bin_t b);
		logic signed [63:0] tr [4], ti [4], w [16], p, f;
		fstat_res_t r;
		bit sing;
		for (int i = 0; i < 4; i++) begin
			tr[i] = $signed(b.t_re[i]);
			ti[i] = $signed(b.t_im[i]);
		end
		if (b.noise != 0) begin
			for (int i = 0; i < 4; i++) begin
				corr_acc[i] = add_clip(corr_acc[i],
					weighted_term(64'(b.d_re) * tr[i], 64'(b.d_im) * ti[i], b.noise));
				for (int j = i; j < 4; j++)
					gram_acc[gram_slot[i*4+j]] = add_clip(gram_acc[gram_slot[i*4+j]],
						weighted_term(tr[i] * tr[j], ti[i] * ti[j], b.noise));
			end
		end
		if (!b.last) return;
		for (int i = 0; i < 16; i++) w[i] = gram_acc[gram_slot[i]];
		sing = 0;
		for (int k = 0; k < 4 && !sing; k++) begin
			p = w[k*5];
			if (p == 0) begin
				sing = 1;
			end else begin
				w[k*5] = 64'sd1 <<< fsmf_pkg::FRAC_BITS;
				for (int j = 0; j < 4; j++) w[k*4+j] = fx_div(w[k*4+j], p);
				for (int i = 0; i < 4; i++) begin
					if (i != k) begin
						f = w[i*4+k];
						w[i*4+k] = 0;
						for (int j = 0; j < 4; j++)
							w[i*4+j] = sub_clip(w[i*4+j], fx_mul(w[k*4+j], f));
					end
				end
			end
		end
		r.fs = 0;
		r.sing = sing;
		for (int i = 0; i < 4; i++) begin
			r.amp[i] = 0;
			if (!sing)
				for (int j = 0; j < 4; j++)
					r.amp[i] = add_clip(r.amp[i], fx_mul(w[i*4+j], corr_acc[j]));
		end
		if (!sing) begin
			for (int i = 0; i < 4; i++) r.fs = add_clip(r.fs, fx_mul(corr_acc[i], r.amp[i]));
			r.fs = r.fs / 2;
		end
		window_results.push_back(r);
		clear_sums();
	endfunction

	task automatic send_bin(input bin_t b);
		bit took;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_re <= b.d_re;
		data_im <= b.d_im;
		tmpl1_re <= b.t_re[0];
		tmpl1_im <= b.t_im[0];
		tmpl2_re <= b.t_re[1];
		tmpl2_im <= b.t_im[1];
		tmpl3_re <= b.t_re[2];
		tmpl3_im <= b.t_im[2];
		tmpl4_re <= b.t_re[3];
		tmpl4_im <= b.t_im[3];
		noise_psd <= b.noise;
		last_bin <= b.last;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		fold_bin(b);
		bins_sent++;
	endtask

	function automatic logic [23:0] rand_smp();
		case ($urandom_range(0, 9))
			0: return 24'(SMP_MAX);
			1: return 24'(SMP_MIN);
			2: return 24'($urandom_range(0, 255)) - 24'd128;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic bin_t rand_bin(input bit last);
		bin_t b;
		b.d_re = rand_smp();
		b.d_im = rand_smp();
		for (int i = 0; i < 4; i++) begin
			b.t_re[i] = rand_smp();
			b.t_im[i] = rand_smp();
		end
		case ($urandom_range(0, 19))
			0, 1, 2, 3: b.noise = 0;
			4: b.noise = 1;
			5, 6: b.noise = $urandom;
			7: b.noise = 32'hffff_ffff;
			default: b.noise = $urandom_range(32'h1000, 32'h10_0000);
		endcase
		if ($urandom_range(0, 29) == 0) begin
			b.t_re = '0;
			b.t_im = '0;
		end
		b.last = last;
		return b;
	endfunction

	task automatic test_directed();
		bin_t b;
		// full-scale samples at the smallest noise: term saturation
		b.d_re = 24'(SMP_MIN);
		b.d_im = 24'(SMP_MIN);
		b.t_re = {4{24'(SMP_MIN)}};
		b.t_im = {4{24'(SMP_MIN)}};
		b.noise = 1;
		b.last = 0;
		send_bin(b);
		b.d_re = 24'(SMP_MAX);
		b.t_re = {4{24'(SMP_MAX)}};
		send_bin(b);
		b.last = 1;
		send_bin(b);
		// all-zero templates: zero pivot
		b.t_re = '0;
		b.t_im = '0;
		b.noise = 32'h1_0000;
		send_bin(b);
		// window of zero-noise bins only, closed by a zero-noise last bin
		b = rand_bin(0);
		b.noise = 0;
		send_bin(b);
		b.last = 1;
		send_bin(b);
		// diagonal templates: well-conditioned two-bin windows
		for (int n = 0; n < 4; n++) begin
			b.d_re = 24'(SMP_MAX);
			b.d_im = 24'(SMP_MIN);
			b.t_re = {24'h40_0000, 24'h0, 24'h0, 24'h0};
			b.t_im = {24'h0, 24'h0, 24'h0, 24'h40_0000};
			b.noise = n == 3 ? 32'hffff_ffff : 32'h1_0000 << n;
			b.last = 0;
			send_bin(b);
			b.t_re = {24'h0, 24'h0, 24'h40_0000, 24'h0};
			b.t_im = {24'h0, 24'hc0_0000, 24'h0, 24'h0};
			b.last = 1;
			send_bin(b);
		end
		for (int n = 0; n < 6; n++) send_bin(rand_bin(n % 3 == 2));
	endtask

	task automatic test_random_windows();
		int len;
		while (bins_sent < 1450) begin
			len = $urandom_range(0, 15) == 0 ? $urandom_range(30, 64) : $urandom_range(1, 12);
			for (int n = 0; n < len; n++) send_bin(rand_bin(n == len - 1));
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 8000;
		for (int n = 0; n < 5; n++) send_bin(rand_bin(1));
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			case (($time / 500) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= $urandom_range(0, 7) != 0;
				default: out_ready <= ($time / 2) % 3 != 0;
			endcase
		end
	end

	always @(negedge clk) begin
		fstat_res_t e;
		logic signed [63:0] got [4];
		if (arst_n && out_valid && out_ready) begin
			if (window_results.size() == 0) begin
				$display("%0t: result with none expected, fstat %0d", $time, fstat);
				errors++;
			end else begin
				e = window_results.pop_front();
				got = '{amp1, amp2, amp3, amp4};
				if (fstat !== e.fs) begin
					$display("%0t: fstat exp %0d got %0d", $time, e.fs, fstat);
					errors++;
				end
				for (int i = 0; i < 4; i++)
					if (got[i] !== e.amp[i]) begin
						$display("%0t: amp%0d exp %0d got %0d", $time, i + 1, e.amp[i], got[i]);
						errors++;
					end
				if (singular !== e.sing) begin
					$display("%0t: singular exp %0b got %0b", $time, e.sing, singular);
					errors++;
				end
			end
		end
	end

	initial begin
		clear_sums();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_windows();
		in_valid <= 1'b0;
		while (window_results.size() != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
